### hdl/bf2d_pkg.sv
// shared widths, defaults and register indexes for the 2d box filter
package bf2d_pkg;

	// default sizes of the stores and counters
	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int MAX_KERNEL_H_DEF = 16;
	localparam int MAX_KERNEL_W_DEF = 16;
	localparam int MAX_HEIGHT_DEF   = 4096;

	// item field widths
	localparam int PIXEL_W   = 8;
	localparam int MEAN_W    = 16;
	localparam int OUT_ROW_W = 12;
	localparam int OUT_COL_W = 10;

	// running sums wrap at these widths
	localparam int COL_SUM_W = 12;
	localparam int WIN_SUM_W = 16;

	// 8.8 mean: window sum scaled by 256 before the divide
	localparam int FRAC_W     = 8;
	localparam int DIVIDEND_W = WIN_SUM_W + FRAC_W;
	localparam int DIV_STEPS  = DIVIDEND_W;

	// stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;

	// configuration port
	localparam int IMG_W_REG_W = 11;
	localparam int KER_REG_W   = 5;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_WIDTH  = 2'd2;

	// register values after reset
	localparam logic [IMG_W_REG_W-1:0] IMAGE_WIDTH_RST   = 11'd1024;
	localparam logic [KER_REG_W-1:0]   KERNEL_HEIGHT_RST = 5'd3;
	localparam logic [KER_REG_W-1:0]   KERNEL_WIDTH_RST  = 5'd3;

endpackage

### hdl/box_filter_2d_top.sv
// top level of the 2d box filter over the valid region
// Pixels enter in raster order on the slave stream, tuser marking the first pixel of a frame;
// each pixel that completes a kernel_height by kernel_width window gives one item holding the
// window mean (unsigned 8.8, truncated) and the window's top-left row and column. The line store
// and the per-column running sums share one ram word per column, read in the accept cycle and
// written back in the next, so no new pixel is taken before the write-back. A pixel that
// completes a window also runs the bit-serial divider for the mean and then hands the item
// to the output register, waiting while the output still holds an untaken item. After reset
// the block clears every column ram word before it takes its first pixel; configuration
// writes are taken at any time.
module box_filter_2d_top #(
	parameter int MAX_WIDTH    = bf2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_KERNEL_H = bf2d_pkg::MAX_KERNEL_H_DEF,
	parameter int MAX_KERNEL_W = bf2d_pkg::MAX_KERNEL_W_DEF,
	parameter int MAX_HEIGHT   = bf2d_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bf2d_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] pixel
	input  logic                             s_tuser,   // [0] frame_start
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bf2d_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] mean, [27:16] out_row,
	                                                    // [37:28] out_col, [39:38] zero
	input  logic                             cfg_we,
	input  logic [bf2d_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bf2d_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bf2d_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = (CW + 1 > IMG_W_REG_W) ? CW + 1 : IMG_W_REG_W;
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int KHW    = $clog2(MAX_KERNEL_H + 1);
	localparam int KWW    = $clog2(MAX_KERNEL_W + 1);
	localparam int SW     = (MAX_KERNEL_H > 1) ? $clog2(MAX_KERNEL_H) : 1;
	localparam int RGW    = (MAX_KERNEL_W > 1) ? $clog2(MAX_KERNEL_W) : 1;
	localparam int DW     = KHW + KWW;
	localparam int LINE_W = MAX_KERNEL_H * PIXEL_W;
	localparam int WORD_W = LINE_W + COL_SUM_W;
	localparam int PAD_W  = M_TDATA_W - MEAN_W - OUT_ROW_W - OUT_COL_W;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_CALC  = 5'b00100,
		S_DIV   = 5'b01000,
		S_PUSH  = 5'b10000
	} state_t;

	// saturating row step
	function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
		if (r < RW'(MAX_HEIGHT - 1)) begin
			row_inc = r + 1'b1;
		end else begin
			row_inc = r;
		end
	endfunction

	// line store slot step, wraps at the store height
	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		if (32'(s) + 1 >= MAX_KERNEL_H) begin
			slot_inc = '0;
		end else begin
			slot_inc = s + 1'b1;
		end
	endfunction

	// column ring step, tracks column modulo the ring size
	function automatic logic [RGW-1:0] ring_inc(input logic [RGW-1:0] g);
		if (32'(g) + 1 >= MAX_KERNEL_W) begin
			ring_inc = '0;
		end else begin
			ring_inc = g + 1'b1;
		end
	endfunction

	state_t                 state_q;
	logic [IMG_W_REG_W-1:0] image_width_q;
	logic [KER_REG_W-1:0]   kernel_height_q;
	logic [KER_REG_W-1:0]   kernel_width_q;
	logic [WW-1:0]          w_eff;
	logic [KHW-1:0]         kh_eff;
	logic [KWW-1:0]         kw_eff;

	logic [CW-1:0]          clr_q;
	logic [RW-1:0]          row_cnt_q;
	logic [CW-1:0]          col_cnt_q;
	logic [SW-1:0]          slot_q;
	logic [RGW-1:0]         ring_q;
	logic [WIN_SUM_W-1:0]   win_sum_q;
	logic [COL_SUM_W-1:0]   recent_q [MAX_KERNEL_W];

	logic                   in_acc;
	logic [RW-1:0]          r_a;
	logic [CW-1:0]          c_a;
	logic [SW-1:0]          slot_a;
	logic [RGW-1:0]         ring_a;

	logic [PIXEL_W-1:0]     item_px_q;
	logic [RW-1:0]          item_row_q;
	logic [CW-1:0]          item_col_q;
	logic [SW-1:0]          item_slot_q;
	logic [RGW-1:0]         item_ring_q;

	logic                   ram_we;
	logic [CW-1:0]          ram_waddr;
	logic [WORD_W-1:0]      ram_wdata;
	logic [WORD_W-1:0]      rd_word;
	logic [MAX_KERNEL_H-1:0][PIXEL_W-1:0] rd_bytes;
	logic [MAX_KERNEL_H-1:0][PIXEL_W-1:0] wr_bytes;
	logic [COL_SUM_W-1:0]   rd_cs;

	logic [SW:0]            old_slot_sum;
	logic [SW-1:0]          old_slot;
	logic [COL_SUM_W-1:0]   cs_base;
	logic [COL_SUM_W-1:0]   cs_sub;
	logic [COL_SUM_W-1:0]   cs_new;
	logic [RGW:0]           old_ring_sum;
	logic [RGW-1:0]         old_ring;
	logic [WIN_SUM_W-1:0]   ws_base;
	logic [WIN_SUM_W-1:0]   ws_sub;
	logic [WIN_SUM_W-1:0]   ws_new;
	logic                   emit;
	logic                   col_last;

	logic                   div_start;
	logic [DW-1:0]          div_divisor;
	logic                   div_done;
	logic [MEAN_W-1:0]      div_quot;

	logic                   push_now;
	logic                   out_valid_q;
	logic [MEAN_W-1:0]      mean_q;
	logic [OUT_ROW_W-1:0]   out_row_q;
	logic [OUT_COL_W-1:0]   out_col_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= IMAGE_WIDTH_RST;
			kernel_height_q <= KERNEL_HEIGHT_RST;
			kernel_width_q  <= KERNEL_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[IMG_W_REG_W-1:0];
				end
				CFG_KERNEL_HEIGHT: begin
					kernel_height_q <= cfg_data[KER_REG_W-1:0];
				end
				CFG_KERNEL_WIDTH: begin
					kernel_width_q <= cfg_data[KER_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// registers clamped to their usable ranges
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		if (kernel_height_q == '0) begin
			kh_eff = KHW'(1);
		end else if (32'(kernel_height_q) > MAX_KERNEL_H) begin
			kh_eff = KHW'(MAX_KERNEL_H);
		end else begin
			kh_eff = KHW'(kernel_height_q);
		end
		if (kernel_width_q == '0) begin
			kw_eff = KWW'(1);
		end else if (32'(kernel_width_q) > MAX_KERNEL_W) begin
			kw_eff = KWW'(MAX_KERNEL_W);
		end else begin
			kw_eff = KWW'(kernel_width_q);
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// position of the incoming item
	always_comb begin
		if (s_tuser) begin
			r_a    = '0;
			c_a    = '0;
			slot_a = '0;
			ring_a = '0;
		end else begin
			r_a    = row_cnt_q;
			c_a    = col_cnt_q;
			slot_a = slot_q;
			ring_a = ring_q;
			if (WW'(col_cnt_q) >= w_eff) begin
				c_a    = '0;
				ring_a = '0;
				r_a    = row_inc(row_cnt_q);
				slot_a = slot_inc(slot_q);
			end
		end
	end

	// item registers, held until the next accept
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_px_q   <= s_tdata[PIXEL_W-1:0];
			item_row_q  <= r_a;
			item_col_q  <= c_a;
			item_slot_q <= slot_a;
			item_ring_q <= ring_a;
		end
	end

	// column word: line store bytes below, column sum on top
	assign rd_bytes = rd_word[LINE_W-1:0];
	assign rd_cs    = rd_word[WORD_W-1:LINE_W];

	// vertical running sum for the item's column
	always_comb begin
		old_slot_sum = (SW+1)'(item_slot_q) + (SW+1)'(MAX_KERNEL_H) - (SW+1)'(kh_eff);
		if (32'(old_slot_sum) >= MAX_KERNEL_H) begin
			old_slot_sum = old_slot_sum - (SW+1)'(MAX_KERNEL_H);
		end
		old_slot = SW'(old_slot_sum);
		cs_base  = (item_row_q == '0) ? '0 : rd_cs;
		if (32'(item_row_q) >= 32'(kh_eff)) begin
			cs_sub = COL_SUM_W'(rd_bytes[old_slot]);
		end else begin
			cs_sub = '0;
		end
		cs_new = cs_base + COL_SUM_W'(item_px_q) - cs_sub;
		wr_bytes = rd_bytes;
		wr_bytes[item_slot_q] = item_px_q;
	end

	// horizontal running sum over the last column sums
	always_comb begin
		old_ring_sum = (RGW+1)'(item_ring_q) + (RGW+1)'(MAX_KERNEL_W) - (RGW+1)'(kw_eff);
		if (32'(old_ring_sum) >= MAX_KERNEL_W) begin
			old_ring_sum = old_ring_sum - (RGW+1)'(MAX_KERNEL_W);
		end
		old_ring = RGW'(old_ring_sum);
		ws_base  = (item_col_q == '0) ? '0 : win_sum_q;
		if (32'(item_col_q) >= 32'(kw_eff)) begin
			ws_sub = WIN_SUM_W'(recent_q[old_ring]);
		end else begin
			ws_sub = '0;
		end
		ws_new   = ws_base + WIN_SUM_W'(cs_new) - ws_sub;
		emit     = (32'(item_row_q) + 1 >= 32'(kh_eff)) && (32'(item_col_q) + 1 >= 32'(kw_eff));
		col_last = (WW'(item_col_q) + 1'b1 >= w_eff);
	end

	// ram write: clearing pass after reset, else write-back of the column word
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = item_col_q;
		ram_wdata = {cs_new, wr_bytes};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_CALC) begin
			ram_we = 1'b1;
		end
	end

	bf2d_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_WIDTH)
	) u_col_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (c_a),
		.rdata (rd_word)
	);

	// mean divider
	assign div_start   = (state_q == S_CALC) && emit;
	assign div_divisor = DW'(kh_eff) * DW'(kw_eff);

	bf2d_div #(
		.DIVISOR_W (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({ws_new, {FRAC_W{1'b0}}}),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			row_cnt_q <= '0;
			col_cnt_q <= '0;
			slot_q    <= '0;
			ring_q    <= '0;
			win_sum_q <= '0;
			for (int i = 0; i < MAX_KERNEL_W; i++) begin
				recent_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(MAX_WIDTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					win_sum_q             <= ws_new;
					recent_q[item_ring_q] <= cs_new;
					if (col_last) begin
						col_cnt_q <= '0;
						ring_q    <= '0;
						row_cnt_q <= row_inc(item_row_q);
						slot_q    <= slot_inc(item_slot_q);
					end else begin
						col_cnt_q <= item_col_q + 1'b1;
						ring_q    <= ring_inc(item_ring_q);
						row_cnt_q <= item_row_q;
						slot_q    <= item_slot_q;
					end
					state_q <= emit ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (push_now) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// output register
	assign push_now = (state_q == S_PUSH) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_now) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_now) begin
			mean_q    <= div_quot;
			out_row_q <= OUT_ROW_W'(item_row_q - RW'(kh_eff - 1'b1));
			out_col_q <= OUT_COL_W'(item_col_q - CW'(kw_eff - 1'b1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_col_q, out_row_q, mean_q};

	// divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> state_q == S_DIV)
		else $error("divider done outside the divide phase");

	// a new output item comes only from the hand-over phase
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_PUSH)
		else $error("output item loaded outside the hand-over phase");

	// line store slot stays within the store height
	assert property (@(posedge clk) disable iff (!arst_n) 32'(slot_q) < MAX_KERNEL_H)
		else $error("line store slot out of range");

	// column ring index stays within the ring
	assert property (@(posedge clk) disable iff (!arst_n) 32'(ring_q) < MAX_KERNEL_W)
		else $error("column ring index out of range");

endmodule

### hdl/bf2d_ram.sv
// generic simple dual-port ram with registered read
module bf2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/bf2d_div.sv
// bit-serial restoring divider for the window mean
module bf2d_div #(
	parameter int DIVISOR_W = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [bf2d_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]            divisor,
	output logic                            done,
	output logic [bf2d_pkg::MEAN_W-1:0]     quotient
);
	import bf2d_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [MEAN_W-1:0]     quo_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// next partial remainder and quotient bit
	assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, only the low bits are kept
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dsr_q}) : trial[DIVISOR_W-1:0];
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			quo_q <= {quo_q[MEAN_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### tb/tb_box_filter_2d_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the 2d box filter top level
module tb_box_filter_2d_top;
	import bf2d_pkg::*;

	localparam int QUIET_CYCLES   = 40;
	localparam int RANDOM_PIXELS  = 250;
	localparam int MAX_REPORTS    = 10;
	localparam int TIMEOUT_CYCLES = 2_000_000;
	localparam int PLAN_LEN       = 37;
	localparam int COL_SUM_MASK   = (1 << COL_SUM_W) - 1;
	localparam int WIN_SUM_MASK   = (1 << WIN_SUM_W) - 1;

	// one window result as it leaves the block
	typedef struct packed {
		logic [MEAN_W-1:0]    mean;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
	} window_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} plan_kind_t;

	// one line of the directed plan: a pixel item or a register write
	typedef struct packed {
		plan_kind_t             kind;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
		logic [PIXEL_W-1:0]     pixel;
		logic                   first;
		logic                   typed;
		window_t                want;
	} plan_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// mirror of the filter state
	logic [PIXEL_W-1:0]     line_mem [MAX_KERNEL_H_DEF][MAX_WIDTH_DEF];
	logic [COL_SUM_W-1:0]   col_sum [MAX_WIDTH_DEF];
	logic [COL_SUM_W-1:0]   recent_sum [MAX_KERNEL_W_DEF];
	logic [WIN_SUM_W-1:0]   win_sum   = '0;
	int unsigned            row_ptr   = 0;
	int unsigned            col_ptr   = 0;
	int unsigned            slot      = 0;
	logic [IMG_W_REG_W-1:0] reg_width = IMAGE_WIDTH_RST;
	logic [KER_REG_W-1:0]   reg_kh    = KERNEL_HEIGHT_RST;
	logic [KER_REG_W-1:0]   reg_kw    = KERNEL_WIDTH_RST;

	window_t pending_windows[$];
	bit      steady          = 1'b0;
	int      rx_hold         = 0;
	int      rx_gap;
	int      fail_count      = 0;
	int      pixels_sent     = 0;
	int      windows_checked = 0;
	int      regs_written    = 0;

	box_filter_2d_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] pixel
		.s_tuser  (s_tuser),   // [0] frame_start
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [15:0] mean, [27:16] out_row, [37:28] out_col
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle cycles before the next item, none during a steady stretch
	function automatic int pause_len();
		return steady ? 0 : int'($urandom_range(0, 4));
	endfunction

	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// move to the next image row, row counter saturates, line slot rolls
	function automatic void next_line(inout int unsigned r);
		if (r < MAX_HEIGHT_DEF - 1) r++;
		slot = (slot + 1 >= MAX_KERNEL_H_DEF) ? 0 : slot + 1;
	endfunction

	// advance the filter state by one pixel, returns 1 when a window completes
	function automatic bit box_mean_step(input logic [PIXEL_W-1:0] px, input logic first,
	                                     output window_t res);
		int unsigned w, kh, kw, r, c, cs, ws, old_cs, old_px;
		bit hit;
		w  = clamp_reg(32'(reg_width), MAX_WIDTH_DEF);
		kh = clamp_reg(32'(reg_kh), MAX_KERNEL_H_DEF);
		kw = clamp_reg(32'(reg_kw), MAX_KERNEL_W_DEF);
		res = '0;
		if (first) begin
			r    = 0;
			c    = 0;
			slot = 0;
		end else begin
			r = row_ptr;
			c = col_ptr;
			// column past a narrowed width starts the next row
			if (c >= w) begin
				c = 0;
				next_line(r);
			end
		end
		// vertical sum over the last kh rows of this column
		old_px = 32'(line_mem[(slot + MAX_KERNEL_H_DEF - kh) % MAX_KERNEL_H_DEF][c]);
		cs = (r == 0) ? 0 : 32'(col_sum[c]);
		cs = cs + 32'(px);
		if (r >= kh) cs = cs - old_px;
		cs = cs & COL_SUM_MASK;
		col_sum[c] = COL_SUM_W'(cs);
		line_mem[slot][c] = px;
		// horizontal sum over the last kw column sums
		old_cs = 32'(recent_sum[(c + MAX_KERNEL_W_DEF - kw) % MAX_KERNEL_W_DEF]);
		ws = (c == 0) ? 0 : 32'(win_sum);
		ws = ws + cs;
		if (c >= kw) ws = ws - old_cs;
		ws = ws & WIN_SUM_MASK;
		win_sum = WIN_SUM_W'(ws);
		recent_sum[c % MAX_KERNEL_W_DEF] = COL_SUM_W'(cs);
		hit = (r + 1 >= kh) && (c + 1 >= kw);
		if (hit) begin
			res.mean = MEAN_W'((ws << FRAC_W) / (kh * kw));
			res.row  = OUT_ROW_W'(r + 1 - kh);
			res.col  = OUT_COL_W'(c + 1 - kw);
		end
		if (c + 1 >= w) begin
			col_ptr = 0;
			next_line(r);
		end else begin
			col_ptr = c + 1;
		end
		row_ptr = r;
		return hit;
	endfunction

	// plan lines
	function automatic plan_row_t px_row(logic [PIXEL_W-1:0] px, logic first);
		plan_row_t p;
		p = '0;
		p.kind  = ROW_PIXEL;
		p.pixel = px;
		p.first = first;
		return p;
	endfunction

	function automatic plan_row_t px_known(logic [PIXEL_W-1:0] px, logic first,
	                                       logic [MEAN_W-1:0] mean, logic [OUT_ROW_W-1:0] row,
	                                       logic [OUT_COL_W-1:0] col);
		plan_row_t p;
		p = px_row(px, first);
		p.typed     = 1'b1;
		p.want.mean = mean;
		p.want.row  = row;
		p.want.col  = col;
		return p;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_INDEX_W-1:0] idx,
	                                      logic [CFG_DATA_W-1:0] val);
		plan_row_t p;
		p = '0;
		p.kind  = ROW_WRITE;
		p.index = idx;
		p.value = val;
		return p;
	endfunction

	// random stimulus values, extremes favoured
	function automatic logic [PIXEL_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIXEL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return CFG_DATA_W'($urandom_range(1, 8));
			6, 7: return CFG_DATA_W'($urandom_range(9, 40));
			8: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return CFG_DATA_W'(1);
					2: return CFG_DATA_W'(MAX_WIDTH_DEF);
					default: return '1;
				endcase
			end
			default: return CFG_DATA_W'($urandom_range(0, 2047));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_kernel();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: return CFG_DATA_W'($urandom_range(1, 4));
			7: return $urandom_range(0, 1) ? CFG_DATA_W'(MAX_KERNEL_H_DEF) : '0;
			8: return CFG_DATA_W'($urandom_range(5, 16));
			// upper bits are dropped by the register
			default: return CFG_DATA_W'($urandom_range(0, 2047));
		endcase
	endfunction

	function automatic void log_failure(string what, window_t want, window_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s: expected mean %h row %0d col %0d, got mean %h row %0d col %0d",
			         what, want.mean, want.row, want.col, got.mean, got.row, got.col);
	endfunction

	// offer one pixel item and predict what it causes
	task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic first,
	                          input logic typed, input window_t want);
		int gap;
		window_t res;
		bit hit;
		gap = pause_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		s_tuser  <= first;
		do @(posedge clk); while (s_tready !== 1'b1);
		hit = box_mean_step(px, first, res);
		if (hit || typed) pending_windows.push_back(typed ? want : res);
		pixels_sent++;
	endtask

	// stop sending, wait for every pending result, then wait out the extra cycles asked for
	task automatic wait_quiet(input int extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_windows.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_IMAGE_WIDTH:   reg_width = val[IMG_W_REG_W-1:0];
			CFG_KERNEL_HEIGHT: reg_kh    = val[KER_REG_W-1:0];
			CFG_KERNEL_WIDTH:  reg_kw    = val[KER_REG_W-1:0];
			default: ;
		endcase
		regs_written++;
	endtask

	task automatic set_filter(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] kh,
	                          input logic [CFG_DATA_W-1:0] kw);
		wait_quiet(QUIET_CYCLES);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_KERNEL_HEIGHT, kh);
		write_reg(CFG_KERNEL_WIDTH, kw);
	endtask

	// result side: random stall before each item
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold  <= 0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			if (rx_hold == 1) m_tready <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			rx_gap = pause_len();
			if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_hold  <= rx_gap;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each accepted item with the oldest prediction
	always @(posedge clk) begin : check_results
		window_t got, want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got.mean = m_tdata[MEAN_W-1:0];
			got.row  = m_tdata[MEAN_W +: OUT_ROW_W];
			got.col  = m_tdata[MEAN_W + OUT_ROW_W +: OUT_COL_W];
			windows_checked++;
			if (pending_windows.size() == 0) begin
				log_failure("unexpected item", '0, got);
			end else begin
				want = pending_windows.pop_front();
				if (got.mean !== want.mean || got.row !== want.row || got.col !== want.col)
					log_failure("mismatch", want, got);
			end
		end
	end

	// watchdog
	initial begin : watchdog
		#(64'd10 * TIMEOUT_CYCLES);
		$display("timeout with %0d results outstanding", pending_windows.size());
		$display("tb_box_filter_2d_top failed");
		$finish;
	end

	initial begin : stimulus
		plan_row_t plan [PLAN_LEN];
		window_t none;
		int sent, frame_len, rows, kind;
		logic first;

		// mirror state after reset
		for (int i = 0; i < MAX_KERNEL_H_DEF; i++)
			for (int j = 0; j < MAX_WIDTH_DEF; j++)
				line_mem[i][j] = '0;
		for (int j = 0; j < MAX_WIDTH_DEF; j++) col_sum[j] = '0;
		for (int j = 0; j < MAX_KERNEL_W_DEF; j++) recent_sum[j] = '0;
		none = '0;

		plan = '{
			// no frame start yet, reset sizes: nothing completes
			px_row(8'h00, 1'b0),
			px_row(8'hFF, 1'b0),
			// 1x1 kernel on a 2 wide image
			reg_row(CFG_IMAGE_WIDTH, 11'd2),
			reg_row(CFG_KERNEL_HEIGHT, 11'd1),
			reg_row(CFG_KERNEL_WIDTH, 11'd1),
			px_known(8'hFF, 1'b1, 16'hFF00, 12'd0, 10'd0),
			px_known(8'h00, 1'b0, 16'h0000, 12'd0, 10'd1),
			px_known(8'h80, 1'b0, 16'h8000, 12'd1, 10'd0),
			px_row(8'h07, 1'b0),
			// zero registers clamp up to 1
			reg_row(CFG_IMAGE_WIDTH, 11'd0),
			reg_row(CFG_KERNEL_HEIGHT, 11'd0),
			reg_row(CFG_KERNEL_WIDTH, 11'd0),
			px_known(8'h01, 1'b1, 16'h0100, 12'd0, 10'd0),
			px_known(8'h02, 1'b0, 16'h0200, 12'd1, 10'd0),
			// oversized registers clamp down, upper kernel bits dropped
			reg_row(CFG_IMAGE_WIDTH, 11'h7FF),
			reg_row(CFG_KERNEL_HEIGHT, 11'd31),
			reg_row(CFG_KERNEL_WIDTH, 11'h7F0),
			px_row(8'hC8, 1'b1),
			px_row(8'h64, 1'b0),
			// kernel wider than the image never completes
			reg_row(CFG_IMAGE_WIDTH, 11'd4),
			reg_row(CFG_KERNEL_HEIGHT, 11'd1),
			reg_row(CFG_KERNEL_WIDTH, 11'd8),
			px_row(8'hFF, 1'b1),
			px_row(8'hFF, 1'b0),
			px_row(8'hFF, 1'b0),
			px_row(8'hFF, 1'b0),
			px_row(8'hFF, 1'b0),
			// width narrowed below the current column mid-row
			reg_row(CFG_IMAGE_WIDTH, 11'd8),
			reg_row(CFG_KERNEL_WIDTH, 11'd1),
			px_row(8'h0A, 1'b1),
			px_row(8'h14, 1'b0),
			px_row(8'h1E, 1'b0),
			px_row(8'h28, 1'b0),
			px_row(8'h32, 1'b0),
			reg_row(CFG_IMAGE_WIDTH, 11'd3),
			px_known(8'h3C, 1'b0, 16'h3C00, 12'd1, 10'd0),
			px_row(8'h46, 1'b0)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (i == 0 || plan[i-1].kind == ROW_PIXEL) wait_quiet(QUIET_CYCLES);
				write_reg(plan[i].index, plan[i].value);
			end else begin
				send_pixel(plan[i].pixel, plan[i].first, plan[i].typed, plan[i].want);
			end
		end

		// largest kernel, sums at their top values
		set_filter(CFG_DATA_W'(MAX_KERNEL_W_DEF), CFG_DATA_W'(MAX_KERNEL_H_DEF),
		           CFG_DATA_W'(MAX_KERNEL_W_DEF));
		for (int j = 0; j < (MAX_KERNEL_H_DEF + 1) * MAX_KERNEL_W_DEF; j++)
			send_pixel($urandom_range(0, 3) == 0 ? rand_pixel() : 8'hFF, j == 0, 1'b0, none);

		// random frames: mostly well formed, some continued or broken
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			if (sent == 0 || $urandom_range(0, 2) == 0) begin
				set_filter(pick_width(), pick_kernel(), pick_kernel());
				steady = ($urandom_range(0, 3) == 0);
			end
			rows = int'(clamp_reg(32'(reg_kh), MAX_KERNEL_H_DEF) + $urandom_range(0, 2));
			frame_len = rows * int'(clamp_reg(32'(reg_width), MAX_WIDTH_DEF));
			if (frame_len > 60) frame_len = int'($urandom_range(1, 60));
			kind = int'($urandom_range(0, 9));
			for (int j = 0; j < frame_len; j++) begin
				if (kind == 0)
					first = ($urandom_range(0, 7) == 0);
				else
					first = (j == 0 && kind != 1);
				send_pixel(rand_pixel(), first, 1'b0, none);
			end
			sent += frame_len;
			// hold the source until the pipeline has emptied
			if ($urandom_range(0, 9) == 0) wait_quiet(0);
		end

		wait_quiet(QUIET_CYCLES);
		$display("sent %0d pixel items with %0d register writes, checked %0d window results",
		         pixels_sent, regs_written, windows_checked);
		$display("%0d failures", fail_count);
		if (fail_count == 0) begin
			$display("tb_box_filter_2d_top passed");
		end else begin
			$display("tb_box_filter_2d_top failed");
		end
		$finish;
	end

endmodule
